/* src/gshw_pkg.sv */
`timescale 1ns / 1ps

package gshw_pkg;

  localparam int IN_W      = 31;   // offset fields
  localparam int SSUM_W    = 62;   // x^2 + y^2
  localparam int SIG2_W    = 48;   // sigma^2
  localparam int QUO_W     = 21;   // radial exponent E1, Q16
  localparam int LOG_W     = 21;   // log2, 5 integer + 16 fraction bits
  localparam int FRAC_W    = 16;
  localparam int POW_W     = 32;   // 2^f in Q30
  localparam int CFG_W     = 24;
  localparam int SHAPE_W   = 18;
  localparam int W_W       = 18;
  localparam int PIPE_LAST = 76;   // stage holding the result

  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [20:0] E_CAP     = 21'd1572864;   // 24.0 in Q16
  localparam logic [17:0] W_MAX     = 18'd131072;    // 2.0 in Q2.16
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;

  typedef enum logic [1:0] {
    CFG_SPOT_SIGMA  = 2'd0,
    CFG_DEPTH_SCALE = 2'd1,
    CFG_SHAPE_EXP   = 2'd2
  } cfg_idx_t;

  // depth path side info, waits beside the first 2^f unit
  typedef struct packed {
    logic [5:0] sh;
    logic       zz;
    logic       pbig;
  } dside_t;

  // radial path result, waits for the depth term
  typedef struct packed {
    logic [20:0] e1;
    logic        big;
  } rside_t;

  // final power side info
  typedef struct packed {
    logic [5:0] sh;
    logic       kill;
  } fside_t;

  // floor(x / i) = (x * div_mag(i)) >> div_sh(i), exact for x < 2^30
  function automatic logic [30:0] div_mag(input int i);
    logic [30:0] r;
    case (i)
      3:       r = 31'd1431655766;
      5:       r = 31'd1717986919;
      6:       r = 31'd1431655766;
      7:       r = 31'd1227133514;
      9:       r = 31'd1908874354;
      10:      r = 31'd1717986919;
      11:      r = 31'd1561806290;
      12:      r = 31'd1431655766;
      default: r = 31'd1073741824;   // powers of two
    endcase
    return r;
  endfunction

  function automatic int div_sh(input int i);
    int r;
    case (i)
      1:       r = 30;
      2:       r = 31;
      3, 4:    r = 32;
      5, 6, 7, 8: r = 33;
      default: r = 34;
    endcase
    return r;
  endfunction

  // round(m / 2^s), zero once s reaches 32 (m < 2^31)
  function automatic logic [32:0] rnd_shift(input logic [31:0] m, input logic [5:0] s);
    logic [32:0] r;
    r = '0;
    if (s < 6'd32) begin
      r = ({1'b0, m} + (33'd1 << (s - 6'd1))) >> s;
    end
    return r;
  endfunction

endpackage

/* src/gshw_log2.sv */
`timescale 1ns / 1ps

// log2 in Q16, 17 stages: normalize, then one mantissa squaring per fraction bit
module gshw_log2 (
  input  logic                          clk,
  input  logic                          en,
  input  logic [gshw_pkg::IN_W-1:0]     val_i,
  output logic [gshw_pkg::LOG_W-1:0]    log_o
);

  logic [4:0]  msb_w;
  logic [30:0] norm_w;
  logic [61:0] sq_w [1:16];
  logic [30:0] m_r  [0:16];
  logic [4:0]  e_r  [0:16];
  logic [15:0] fr_r [0:16];

  always_comb begin
    msb_w = '0;
    for (int b = 1; b < 31; b++) begin
      if (val_i[b]) msb_w = 5'(b);
    end
    norm_w = val_i << (5'd30 - msb_w);
    for (int k = 1; k <= 16; k++) begin
      sq_w[k] = 62'(m_r[k-1]) * 62'(m_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0]  <= norm_w;
      e_r[0]  <= msb_w;
      fr_r[0] <= '0;
      for (int k = 1; k <= 16; k++) begin
        e_r[k]  <= e_r[k-1];
        fr_r[k] <= {fr_r[k-1][14:0], sq_w[k][61]};
        m_r[k]  <= sq_w[k][61] ? sq_w[k][61:31] : sq_w[k][60:30];
      end
    end
  end

  assign log_o = {e_r[16], fr_r[16]};

endmodule

/* src/gshw_exp2.sv */
`timescale 1ns / 1ps

// 2^(f/65536) in Q30, 25 stages: scale by ln2, then 12 series terms,
// each a multiply by w and a reciprocal multiply for the 1/i
module gshw_exp2 (
  input  logic                          clk,
  input  logic                          en,
  input  logic [gshw_pkg::FRAC_W-1:0]   frac_i,
  output logic [gshw_pkg::POW_W-1:0]    pow_o
);

  logic [45:0] wp_w;
  logic [61:0] pa_w [1:12];
  logic [61:0] pb_w [1:12];
  logic [30:0] tq_w [1:12];
  logic [29:0] w_r   [0:22];
  logic [30:0] val_r [0:23];
  logic [31:0] sum_r [0:24];

  always_comb begin
    wp_w = 46'(frac_i) * 46'(gshw_pkg::LN2_Q30);
    for (int i = 1; i <= 12; i++) begin
      pa_w[i] = 62'(val_r[2*i-2]) * 62'(w_r[2*i-2]);
      pb_w[i] = 62'(val_r[2*i-1]) * 62'(gshw_pkg::div_mag(i));
      tq_w[i] = 31'(pb_w[i] >> gshw_pkg::div_sh(i));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r[0]   <= wp_w[45:16];
      val_r[0] <= gshw_pkg::ONE_Q30;
      sum_r[0] <= 32'(gshw_pkg::ONE_Q30);
      for (int k = 1; k <= 22; k++) begin
        w_r[k] <= w_r[k-1];
      end
      for (int i = 1; i <= 12; i++) begin
        val_r[2*i-1] <= pa_w[i][60:30];
        sum_r[2*i-1] <= sum_r[2*i-2];
        sum_r[2*i]   <= sum_r[2*i-1] + 32'(tq_w[i]);
      end
      for (int i = 1; i <= 11; i++) begin
        val_r[2*i] <= tq_w[i];
      end
    end
  end

  assign pow_o = sum_r[24];

endmodule

/* src/gshw_div.sv */
`timescale 1ns / 1ps

// floor(num * 2^15 / den), 22 stages: range check, 6 integer bits, 15 fraction bits
module gshw_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [gshw_pkg::SSUM_W-1:0]   num_i,
  input  logic [gshw_pkg::SIG2_W-1:0]   den_i,
  output logic [gshw_pkg::QUO_W-1:0]    quo_o,
  output logic                          big_o
);

  logic [53:0] thr_w;
  logic [61:0] ci_w [1:6];
  logic [48:0] rs_w [7:21];
  logic [61:0] ri_r [0:6];
  logic [47:0] rf_r [7:20];
  logic [20:0] q_r  [0:21];
  logic        big_r [0:21];

  always_comb begin
    thr_w = 54'({den_i, 5'd0}) + 54'({den_i, 4'd0});   // 48 * den
    for (int k = 1; k <= 6; k++) begin
      ci_w[k] = 62'(den_i) << (6 - k);
    end
    rs_w[7] = {ri_r[6][47:0], 1'b0};
    for (int k = 8; k <= 21; k++) begin
      rs_w[k] = {rf_r[k-1], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ri_r[0]  <= num_i;
      q_r[0]   <= '0;
      big_r[0] <= num_i >= 62'(thr_w);
      for (int k = 1; k <= 21; k++) begin
        big_r[k] <= big_r[k-1];
      end
      for (int k = 1; k <= 6; k++) begin
        if (ri_r[k-1] >= ci_w[k]) begin
          ri_r[k] <= ri_r[k-1] - ci_w[k];
          q_r[k]  <= q_r[k-1] | (21'd1 << (21 - k));
        end else begin
          ri_r[k] <= ri_r[k-1];
          q_r[k]  <= q_r[k-1];
        end
      end
      for (int k = 7; k <= 21; k++) begin
        if (rs_w[k] >= {1'b0, den_i}) begin
          q_r[k] <= q_r[k-1] | (21'd1 << (21 - k));
        end else begin
          q_r[k] <= q_r[k-1];
        end
      end
      for (int k = 7; k <= 20; k++) begin
        if (rs_w[k] >= {1'b0, den_i}) begin
          rf_r[k] <= 48'(rs_w[k] - {1'b0, den_i});
        end else begin
          rf_r[k] <= rs_w[k][47:0];
        end
      end
    end
  end

  assign quo_o = q_r[21];
  assign big_o = big_r[21];

endmodule

/* src/gaussian_superdepth_heat_weight_core.sv */
// Heat-source weight pipeline: 2*exp(-0.5*(r/sigma)^2) * exp(-3*|z/d|^n), Q2.16.
// Throughput: one transaction per cycle; the whole pipeline stalls only while a
//   result sits unaccepted on the output, and then loses and repeats nothing.
// Reset (rst_n low, synchronous): clears all stage valid bits and loads the
//   registers with sigma 50000 nm, depth 50000 nm, exponent 2.0.
`timescale 1ns / 1ps

module gaussian_superdepth_heat_weight_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // offset_x_nm[30:0], offset_y_nm[61:31], offset_z_nm[92:62]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // heat_weight[17:0]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);

  localparam int LAST = gshw_pkg::PIPE_LAST;

  // configuration
  logic [23:0] sig_r, dep_r;
  logic [17:0] shape_r;
  logic [47:0] sig2_r;
  logic [23:0] sig_eff, dep_eff;

  // pipeline control
  logic            en, acc;
  logic [LAST:1]   vld_r;

  // S1..S3: magnitudes, squares, radial sum
  logic [30:0] mx_w, my_w, mz_w;
  logic [30:0] ax_r, ay_r, az_r;
  logic [61:0] x2_r, y2_r, ssum_r;
  logic        zz_r [1:18];

  // depth path
  logic [20:0]             lz_w, ld_w;
  logic                    neg19_r, zz19_r;
  logic [20:0]             lmag19_r;
  logic [38:0]             pp_w;
  logic [30:0]             pmag20_r;
  logic                    neg20_r, zz20_r;
  logic [15:0]             sh_w;
  logic [15:0]             f21_nxt, f21_r;
  gshw_pkg::dside_t        d21_nxt;
  gshw_pkg::dside_t        dside_r [21:46];
  logic [31:0]             m1_w;
  logic [20:0]             t47_r;
  logic                    pbig47_r;

  // radial path
  logic [20:0]             quo_w;
  logic                    big_w;
  gshw_pkg::rside_t        rside_r [26:47];

  // combine and final power
  logic [22:0]             e2_w;
  logic [23:0]             esum_w;
  logic [20:0]             e48_r;
  logic                    kill48_r;
  logic [51:0]             gp_w;
  logic [21:0]             g49_r;
  logic                    kill49_r;
  logic [6:0]              gsh_w;
  gshw_pkg::fside_t        f50_nxt;
  logic [15:0]             f50_r;
  gshw_pkg::fside_t        fside_r [50:75];
  logic [31:0]             m2_w;
  logic [32:0]             wv_w;
  logic [17:0]             w_nxt, w_r;

  // global advance: the output register is free or is being emptied
  assign en        = !vld_r[LAST] || out_tready;
  assign in_tready = en;
  assign acc       = in_tvalid && en;

  assign out_tvalid = vld_r[LAST];
  assign out_tdata  = {6'd0, w_r};

  // ---------------------------------------------------------------------------
  // Configuration registers; zero sigma or depth acts as 1 nm
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sig_r   <= 24'd50000;
      dep_r   <= 24'd50000;
      shape_r <= 18'd512;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gshw_pkg::CFG_SPOT_SIGMA:  sig_r   <= cfg_wdata;
        gshw_pkg::CFG_DEPTH_SCALE: dep_r   <= cfg_wdata;
        gshw_pkg::CFG_SHAPE_EXP:   shape_r <= cfg_wdata[17:0];
        default: ;
      endcase
    end
  end

  assign sig_eff = (sig_r == 24'd0) ? 24'd1 : sig_r;
  assign dep_eff = (dep_r == 24'd0) ? 24'd1 : dep_r;

  // sigma^2 is registered from the registered sigma; first used at the divider
  always_ff @(posedge clk) begin
    sig2_r <= 48'(sig_eff) * 48'(sig_eff);
  end

  // ---------------------------------------------------------------------------
  // Valid bits
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAST-1:1], acc};
    end
  end

  // ---------------------------------------------------------------------------
  // S1..S3: magnitudes (most negative gives 2^30), squares, radial sum
  // ---------------------------------------------------------------------------
  assign mx_w = in_tdata[30]  ? (31'd0 - in_tdata[30:0])  : in_tdata[30:0];
  assign my_w = in_tdata[61]  ? (31'd0 - in_tdata[61:31]) : in_tdata[61:31];
  assign mz_w = in_tdata[92]  ? (31'd0 - in_tdata[92:62]) : in_tdata[92:62];

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r     <= mx_w;
      ay_r     <= my_w;
      az_r     <= mz_w;
      zz_r[1]  <= (mz_w == 31'd0);
      for (int k = 2; k <= 18; k++) begin
        zz_r[k] <= zz_r[k-1];
      end
      x2_r   <= 62'(ax_r) * 62'(ax_r);
      y2_r   <= 62'(ay_r) * 62'(ay_r);
      ssum_r <= x2_r + y2_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Radial exponent: E1 = floor(r^2 * 2^15 / sigma^2), S4..S25
  // ---------------------------------------------------------------------------
  gshw_div u_div (
    .clk   (clk),
    .en    (en),
    .num_i (ssum_r),
    .den_i (sig2_r),
    .quo_o (quo_w),
    .big_o (big_w)
  );

  // hold E1 until the depth term is ready (S26..S47)
  always_ff @(posedge clk) begin
    if (en) begin
      rside_r[26] <= '{e1: quo_w, big: big_w};
      for (int k = 27; k <= 47; k++) begin
        rside_r[k] <= rside_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Depth exponent: log2|z| and log2 d side by side, S2..S18
  // ---------------------------------------------------------------------------
  gshw_log2 u_log_z (
    .clk   (clk),
    .en    (en),
    .val_i (az_r),
    .log_o (lz_w)
  );

  gshw_log2 u_log_d (
    .clk   (clk),
    .en    (en),
    .val_i (31'(dep_eff)),
    .log_o (ld_w)
  );

  // S19: |L| and its sign; S20: P = n*|L| / 256
  assign pp_w = 39'(shape_r) * 39'(lmag19_r);

  always_ff @(posedge clk) begin
    if (en) begin
      neg19_r  <= lz_w < ld_w;
      lmag19_r <= (lz_w < ld_w) ? (ld_w - lz_w) : (lz_w - ld_w);
      zz19_r   <= zz_r[18];
      pmag20_r <= pp_w[38:8];
      neg20_r  <= neg19_r;
      zz20_r   <= zz19_r;
    end
  end

  // S21: fraction for the 2^f unit and rounding shift.
  // Negative L: 2^-P = 2^(1-frac) / 2^(int+1), or 1 / 2^int when frac is zero.
  // Positive L: 2^P = 2^frac * 2^int, int of 4 or more kills the weight.
  always_comb begin
    sh_w        = {1'b0, pmag20_r[30:16]} + {15'd0, (pmag20_r[15:0] != 16'd0)};
    d21_nxt.zz  = zz20_r;
    if (neg20_r) begin
      f21_nxt      = 16'd0 - pmag20_r[15:0];
      d21_nxt.sh   = (sh_w >= 16'd18) ? 6'd32 : 6'(sh_w + 16'd14);
      d21_nxt.pbig = 1'b0;
    end else begin
      f21_nxt      = pmag20_r[15:0];
      d21_nxt.sh   = 6'd14 - {4'd0, pmag20_r[17:16]};
      d21_nxt.pbig = !zz20_r && (pmag20_r[30:16] >= 15'd4);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f21_r       <= f21_nxt;
      dside_r[21] <= d21_nxt;
      for (int k = 22; k <= 46; k++) begin
        dside_r[k] <= dside_r[k-1];
      end
    end
  end

  // S22..S46: 2^f for the depth term
  gshw_exp2 u_exp_depth (
    .clk    (clk),
    .en     (en),
    .frac_i (f21_r),
    .pow_o  (m1_w)
  );

  // S47: t rounded to Q16; zero depth offset makes the exponent zero
  always_ff @(posedge clk) begin
    if (en) begin
      t47_r    <= dside_r[46].zz ? 21'd0 : 21'(gshw_pkg::rnd_shift(m1_w, dside_r[46].sh));
      pbig47_r <= dside_r[46].pbig;
    end
  end

  // ---------------------------------------------------------------------------
  // S48: E = E1 + 3t with the zero-weight checks; S49: G = E * log2(e)
  // ---------------------------------------------------------------------------
  assign e2_w   = {1'b0, t47_r, 1'b0} + 23'(t47_r);
  assign esum_w = 24'(rside_r[47].e1) + 24'(e2_w);
  assign gp_w   = 52'(e48_r) * 52'(gshw_pkg::LOG2E_Q30);

  always_ff @(posedge clk) begin
    if (en) begin
      e48_r    <= esum_w[20:0];
      kill48_r <= rside_r[47].big || pbig47_r || (esum_w >= 24'(gshw_pkg::E_CAP));
      g49_r    <= gp_w[51:30];
      kill49_r <= kill48_r;
    end
  end

  // S50: 2^-G split into fraction and shift, result scaled by 2^17
  always_comb begin
    gsh_w        = {1'b0, g49_r[21:16]} + {6'd0, (g49_r[15:0] != 16'd0)};
    f50_nxt.sh   = (gsh_w >= 7'd19) ? 6'd32 : 6'(gsh_w + 7'd13);
    f50_nxt.kill = kill49_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f50_r       <= 16'd0 - g49_r[15:0];
      fside_r[50] <= f50_nxt;
      for (int k = 51; k <= 75; k++) begin
        fside_r[k] <= fside_r[k-1];
      end
    end
  end

  // S51..S75
  gshw_exp2 u_exp_out (
    .clk    (clk),
    .en     (en),
    .frac_i (f50_r),
    .pow_o  (m2_w)
  );

  // S76: round, saturate at 2.0 or give zero on kill, output register
  always_comb begin
    wv_w = gshw_pkg::rnd_shift(m2_w, fside_r[75].sh);
    if (fside_r[75].kill) begin
      w_nxt = '0;
    end else if (wv_w > 33'(gshw_pkg::W_MAX)) begin
      w_nxt = gshw_pkg::W_MAX;
    end else begin
      w_nxt = wv_w[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r <= w_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_stall_keeps_items: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> vld_r == $past(vld_r))
    else $error("pipeline valid bits changed during a stall");

  a_kill_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
    en && vld_r[LAST-1] && fside_r[75].kill |=> out_tdata[17:0] == 18'd0)
    else $error("out-of-range exponent did not give a zero weight");

  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[17:0] <= gshw_pkg::W_MAX && out_tdata[23:18] == 6'd0)
    else $error("weight above 2.0");

endmodule

/* bench/gaussian_superdepth_heat_weight_core_tb.sv */
`timescale 1ns / 1ps

// Bench for the heat-weight pipeline: a driver streams offset points with random
// gaps, a monitor checks each weight against a fixed-point predictor run at input
// acceptance, and the register set is changed between phases while the pipe is empty.
module gaussian_superdepth_heat_weight_core_tb;

  typedef bit [63:0] u64_t;

  typedef struct {
    logic signed [30:0] x;
    logic signed [30:0] y;
    logic signed [30:0] z;
  } point_t;

  localparam int WATCHDOG_LIMIT = 3000;  // idle cycles; worst stall is the long hold
  localparam int PRESS_CYCLES   = 400;   // long receiver hold, stalls the pipeline

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;    // offset_x_nm[30:0], offset_y_nm[61:31], offset_z_nm[92:62]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;        // heat_weight[17:0]
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  gaussian_superdepth_heat_weight_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor's copy of the registers
  u64_t sigma_nm = 50000;
  u64_t depth_nm = 50000;
  u64_t shape_q8 = 512;

  point_t     pending_points[$];
  logic [17:0] weight_q[$];
  point_t     cur_point;
  int         n_queued = 0;
  int         n_in = 0;
  int         n_out = 0;
  int         n_bad = 0;
  bit         calm = 1'b0;   // no idling in the final phase
  int         in_gap = 0;
  int         out_gap = 0;
  int         press_left = 0;
  bit         pressed = 1'b0;
  int         quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic u64_t mag_of(logic [30:0] v);
    u64_t t;
    t = {33'd0, v};
    if (v[30]) return 64'h8000_0000 - t;
    return t;
  endfunction

  // log2 with 16 fraction bits via repeated squaring of a Q30 mantissa
  function automatic u64_t log2_fix(u64_t v);
    int unsigned e;
    u64_t m, frac;
    e = 0;
    frac = 0;
    while (e < 30 && (v >> (e + 1)) != 0) e++;
    m = v << (30 - e);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= 64'd2147483648) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return (u64_t'(e) << 16) | frac;
  endfunction

  // 2^(f/65536) in Q30, truncated Taylor series
  function automatic u64_t pow2_frac(u64_t f);
    u64_t w, term, sum;
    w = ((f & 64'hFFFF) * 64'd744261118) >> 16;
    term = 64'd1073741824;
    sum = term;
    for (int i = 1; i <= 12; i++) begin
      term = ((term * w) >> 30) / i;
      sum += term;
    end
    return sum;
  endfunction

  // round(2^(-g/65536) * 2^outbits)
  function automatic u64_t pow2_neg(u64_t g, int outbits);
    u64_t gi, gf, m, sh, s;
    gi = g >> 16;
    gf = g & 64'hFFFF;
    if (gf == 0) begin
      m = 64'd1073741824;
      sh = gi;
    end else begin
      m = pow2_frac(64'd65536 - gf);
      sh = gi + 1;
    end
    s = 30 - outbits + sh;
    if (s > 62) return 0;
    return (m + (64'd1 << (s - 1))) >> s;
  endfunction

  function automatic logic [17:0] heat_weight_of(point_t p);
    u64_t ax, ay, az, sig, dep, sig2, ssum, qi, rem, e1, e2, e, g, w;
    u64_t lz, ld, lmag, pmag, t, ip;
    ax = mag_of(p.x);
    ay = mag_of(p.y);
    az = mag_of(p.z);
    sig = (sigma_nm != 0) ? sigma_nm : 1;
    dep = (depth_nm != 0) ? depth_nm : 1;
    sig2 = sig * sig;
    ssum = ax * ax + ay * ay;
    qi = ssum / sig2;
    rem = ssum % sig2;
    if (qi >= 48) return '0;
    e1 = (qi << 15) + ((rem << 15) / sig2);
    e2 = 0;
    if (az != 0) begin
      lz = log2_fix(az);
      ld = log2_fix(dep);
      lmag = (lz < ld) ? ld - lz : lz - ld;
      pmag = (shape_q8 * lmag) >> 8;
      if (lz < ld) begin
        t = pow2_neg(pmag, 16);
      end else begin
        ip = pmag >> 16;
        if (ip >= 4) return '0;
        t = pow2_frac(pmag & 64'hFFFF);
        t = (t + (64'd1 << (13 - ip))) >> (14 - ip);
      end
      e2 = 3 * t;
    end
    e = e1 + e2;
    if (e >= (64'd24 << 16)) return '0;
    g = (e * 64'd1549082005) >> 30;
    w = pow2_neg(g, 17);
    if (w > 64'd131072) w = 64'd131072;
    return w[17:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: input transactions, expectation pushed at acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        weight_q.push_back(heat_weight_of(cur_point));
        n_in++;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_points.size() > 0) begin
          if (!calm && $urandom_range(0, 15) == 0) begin
            in_gap = $urandom_range(0, 18);
            in_tvalid <= 1'b0;
          end else begin
            cur_point = pending_points.pop_front();
            in_tdata <= {3'b000, cur_point.z, cur_point.y, cur_point.x};
            in_tvalid <= 1'b1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: result transactions, random stalls and one long hold-off
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic [17:0] want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_out++;
        if (weight_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("unexpected result: heat_weight=%0d", out_tdata[17:0]);
        end else begin
          want = weight_q.pop_front();
          if (out_tdata[17:0] !== want) begin
            n_bad++;
            if (n_bad <= 10)
              $display("result %0d heat_weight: expected %0d, got %0d",
                       n_out, want, out_tdata[17:0]);
          end
        end
      end
      // hold off long enough that the pipe backs up into in_tready
      if (!pressed && n_in >= 300) begin
        pressed = 1'b1;
        press_left = PRESS_CYCLES;
      end
      if (press_left > 0) begin
        press_left--;
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        out_gap = $urandom_range(0, 18);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles without any transaction while work is outstanding
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (n_queued == n_in && weight_q.size() == 0))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic add_point(int x, int y, int z);
    point_t p;
    p.x = x[30:0];
    p.y = y[30:0];
    p.z = z[30:0];
    pending_points.push_back(p);
    n_queued++;
  endtask

  // offset near the given scale, sometimes anywhere in the 31-bit range
  function automatic int rand_offset(u64_t scale);
    int unsigned lim;
    int v;
    case ($urandom_range(0, 9))
      0:       return $signed({$urandom()} << 1) >>> 1;   // full 31-bit range
      1:       return -1073741824;
      2:       return 0;
      default: begin
        lim = (scale * 4 > 64'd1073741823) ? 1073741823 : int'(scale * 4);
        v = $urandom_range(0, lim);
        return $urandom_range(0, 1) ? -v : v;
      end
    endcase
  endfunction

  task automatic write_regs(u64_t s, u64_t d, u64_t n);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= gshw_pkg::CFG_SPOT_SIGMA;
    cfg_wdata <= s[23:0];
    @(posedge clk);
    cfg_index <= gshw_pkg::CFG_DEPTH_SCALE;
    cfg_wdata <= d[23:0];
    @(posedge clk);
    cfg_index <= gshw_pkg::CFG_SHAPE_EXP;
    cfg_wdata <= n[23:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    sigma_nm = s & 64'hFFFFFF;
    depth_nm = d & 64'hFFFFFF;
    shape_q8 = n & 64'h3FFFF;
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) begin
      // mostly points around the spot and the depth scale
      add_point(rand_offset(sigma_nm), rand_offset(sigma_nm), rand_offset(depth_nm));
    end
  endtask

  task automatic drain;
    while (n_in != n_queued || weight_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    u64_t s, d, n;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed points at reset registers (sigma = depth = 50000, n = 2.0)
    add_point(0, 0, 0);                        // peak weight of 2.0
    add_point(1073741823, 1073741823, 1073741823);
    add_point(-1073741824, -1073741824, -1073741824);  // most negative magnitude
    add_point(-1073741824, 0, 0);
    add_point(50000, 0, 0);
    add_point(0, -50000, 0);
    add_point(0, 0, 50000);                    // |z| = d
    add_point(0, 0, -50000);
    add_point(0, 0, 25000);                    // |z| < d, negative log
    add_point(0, 0, 100000);                   // |z| > d
    add_point(0, 0, 200000);
    add_point(0, 0, 1000000);                  // depth exponent P >= 4
    add_point(346410, 0, 0);                   // r^2 just under 48 sigma^2
    add_point(346411, 0, 0);                   // r^2 at the radial cut
    add_point(200000, 200000, 0);
    add_point(150000, 0, 60000);               // radial and depth terms together
    add_point(1, 1, 1);
    add_point(-1, 1, -1);
    add_point(0, 0, 1);
    add_point(245000, 0, 0);
    run_random(80);
    drain();

    // extremes of the registers
    write_regs(1, 1, 512);
    run_random(80);
    drain();
    write_regs(24'hFFFFFF, 24'hFFFFFF, 131072);
    add_point(1073741823, 0, 16777215);
    add_point(0, 0, 16777216);
    run_random(80);
    drain();
    write_regs(0, 0, 0);                       // zero regs act as 1 nm; n = 0 kept
    run_random(80);
    drain();
    write_regs(1000, 3000, 768);
    run_random(100);
    drain();

    // random register settings, mostly small exponents
    for (int ph = 0; ph < 6; ph++) begin
      s = $urandom_range(1, 24'hFFFFFF) >> $urandom_range(0, 20);
      d = $urandom_range(1, 24'hFFFFFF) >> $urandom_range(0, 20);
      n = $urandom_range(0, 3) ? $urandom_range(512, 2048) : $urandom_range(512, 131072);
      write_regs(s, d, n);
      run_random(130);
      drain();
    end

    // final phase: no idling on either side
    write_regs(50000, 50000, 512);
    calm = 1'b1;
    run_random(150);
    drain();
    repeat (100) @(posedge clk);

    if (n_bad == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

/* gaussian_superdepth_heat_weight_core.f */
src/gshw_pkg.sv
src/gshw_log2.sv
src/gshw_exp2.sv
src/gshw_div.sv
src/gaussian_superdepth_heat_weight_core.sv
bench/gaussian_superdepth_heat_weight_core_tb.sv
